[rtl/gsm_pkg.sv]
// ----------------------------------------------------------------------------
// gsm_pkg
// Shared types and constants of the greedy demand/supply matcher.
// ----------------------------------------------------------------------------
package gsm_pkg;

  localparam int unsigned ListDepthDef = 64;
  localparam int unsigned ValueW       = 31;
  localparam int unsigned KindW        = 2;
  localparam int unsigned MatchW       = 7;

  localparam logic [KindW-1:0] KindDemand = 2'd0;
  localparam logic [KindW-1:0] KindSupply = 2'd1;
  localparam logic [KindW-1:0] KindFinish = 2'd2;
  localparam logic [KindW-1:0] KindNone   = 2'd3;

  typedef struct packed {
    logic load_d;
    logic load_s;
    logic init;
    logic cap_v;
    logic acc_clr;
    logic acc_en;
    logic cmp;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

[rtl/gsm_in_if.sv]
// ----------------------------------------------------------------------------
// gsm_in_if
// Input channel: load and finish beats.
// ----------------------------------------------------------------------------
interface gsm_in_if;
  logic                        valid;
  logic                        ready;
  logic [gsm_pkg::KindW-1:0]   kind;
  logic [gsm_pkg::ValueW-1:0]  value;

  modport source (output valid, kind, value, input ready);
  modport sink (input valid, kind, value, output ready);
endinterface

[rtl/gsm_out_if.sv]
// ----------------------------------------------------------------------------
// gsm_out_if
// Output channel: match count result beats.
// ----------------------------------------------------------------------------
interface gsm_out_if;
  logic                        valid;
  logic                        ready;
  logic [gsm_pkg::MatchW-1:0]  matched_count;
  logic                        overflow;

  modport source (output valid, matched_count, overflow, input ready);
  modport sink (input valid, matched_count, overflow, output ready);
endinterface

[rtl/gsm_ram.sv]
// ----------------------------------------------------------------------------
// gsm_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
module gsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/gsm_datapath.sv]
// ----------------------------------------------------------------------------
// gsm_datapath
// List stores, counts, threshold scan accumulators and result register.
// ----------------------------------------------------------------------------
module gsm_datapath #(
  parameter int unsigned ListDepth = gsm_pkg::ListDepthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gsm_pkg::cmd_t                    cmd_i,
  input  logic [$clog2(ListDepth)-1:0]     rd_addr_i,
  input  logic [$clog2(ListDepth+1)-1:0]   rd_idx_i,
  input  logic [gsm_pkg::ValueW-1:0]       value_i,
  output gsm_pkg::sts_t                    sts_o,
  output logic [$clog2(ListDepth+1)-1:0]   nd_o,
  output logic [$clog2(ListDepth+1)-1:0]   len_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [gsm_pkg::MatchW-1:0]       matched_o,
  output logic                             overflow_o
);

  localparam int unsigned AW = $clog2(ListDepth);
  localparam int unsigned CW = $clog2(ListDepth + 1);
  localparam logic [CW-1:0] Full = CW'(ListDepth);

  logic [CW-1:0]             nd_q, ns_q, dlt_q, sge_q, idx_q;
  logic [CW:0]               best_q, sum;
  logic                      drop_q, acc_vld_q, out_valid_q, ovf_q;
  logic [gsm_pkg::MatchW-1:0] match_q;
  logic [gsm_pkg::ValueW-1:0] v_q, d_rdata, s_rdata;
  logic                      d_we, s_we;
  logic [31:0]               best_w;

  assign d_we = cmd_i.load_d && (nd_q != Full);
  assign s_we = cmd_i.load_s && (ns_q != Full);

  gsm_ram #(.Width(gsm_pkg::ValueW), .Depth(ListDepth)) u_dram (
    .clk_i, .we_i(d_we), .waddr_i(nd_q[AW-1:0]), .wdata_i(value_i),
    .raddr_i(rd_addr_i), .rdata_o(d_rdata)
  );

  gsm_ram #(.Width(gsm_pkg::ValueW), .Depth(ListDepth)) u_sram (
    .clk_i, .we_i(s_we), .waddr_i(ns_q[AW-1:0]), .wdata_i(value_i),
    .raddr_i(rd_addr_i), .rdata_o(s_rdata)
  );

  assign sum    = {1'b0, dlt_q} + {1'b0, sge_q};
  assign best_w = 32'(best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_q        <= '0;
      ns_q        <= '0;
      drop_q      <= 1'b0;
      acc_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_vld_q <= cmd_i.acc_en;
      if (d_we) nd_q <= nd_q + CW'(1);
      if (s_we) ns_q <= ns_q + CW'(1);
      if ((cmd_i.load_d && !d_we) || (cmd_i.load_s && !s_we)) drop_q <= 1'b1;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.fin) begin
        out_valid_q <= 1'b1;
        nd_q        <= '0;
        ns_q        <= '0;
        drop_q      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= rd_idx_i;
    if (cmd_i.init) best_q <= {1'b0, nd_q};
    if (cmd_i.cap_v) v_q <= d_rdata;
    if (cmd_i.acc_clr) begin
      dlt_q <= '0;
      sge_q <= '0;
    end else if (acc_vld_q) begin
      if ((idx_q < nd_q) && (d_rdata < v_q)) dlt_q <= dlt_q + CW'(1);
      if ((idx_q < ns_q) && (s_rdata >= v_q)) sge_q <= sge_q + CW'(1);
    end
    if (cmd_i.cmp && (sum < best_q)) best_q <= sum;
    if (cmd_i.fin) begin
      match_q <= (best_w > 32'd127) ? 7'd127 : best_w[6:0];
      ovf_q   <= drop_q;
    end
  end

  assign sts_o.out_busy = out_valid_q;
  assign nd_o        = nd_q;
  assign len_o       = (nd_q > ns_q) ? nd_q : ns_q;
  assign out_valid_o = out_valid_q;
  assign matched_o   = match_q;
  assign overflow_o  = ovf_q;

endmodule

[rtl/gsm_ctrl.sv]
// ----------------------------------------------------------------------------
// gsm_ctrl
// Sequencer for loading and the threshold scan over both stores.
// ----------------------------------------------------------------------------
module gsm_ctrl #(
  parameter int unsigned ListDepth = gsm_pkg::ListDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic [gsm_pkg::KindW-1:0]      kind_i,
  output logic                           in_ready_o,
  input  gsm_pkg::sts_t                  sts_i,
  input  logic [$clog2(ListDepth+1)-1:0] nd_i,
  input  logic [$clog2(ListDepth+1)-1:0] len_i,
  output gsm_pkg::cmd_t                  cmd_o,
  output logic [$clog2(ListDepth)-1:0]   rd_addr_o,
  output logic [$clog2(ListDepth+1)-1:0] rd_idx_o
);

  localparam int unsigned AW = $clog2(ListDepth);
  localparam int unsigned CW = $clog2(ListDepth + 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRdV   = 3'd1;
  localparam logic [2:0] StCapV  = 3'd2;
  localparam logic [2:0] StScan  = 3'd3;
  localparam logic [2:0] StDrain = 3'd4;
  localparam logic [2:0] StCmp   = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d;
  logic          acc;

  assign in_ready_o = (state_q == StIdle) &&
                      !(sts_i.out_busy && (kind_i == gsm_pkg::KindFinish));
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    cmd_o     = '0;
    rd_idx_o  = j_q;
    rd_addr_o = j_q[AW-1:0];
    case (state_q)
      StIdle: begin
        cmd_o.load_d = acc && (kind_i == gsm_pkg::KindDemand);
        cmd_o.load_s = acc && (kind_i == gsm_pkg::KindSupply);
        if (acc && (kind_i == gsm_pkg::KindFinish)) begin
          cmd_o.init = 1'b1;
          i_d        = '0;
          state_d    = (nd_i == '0) ? StDone : StRdV;
        end
      end
      StRdV: begin
        rd_addr_o = i_q[AW-1:0];
        state_d   = StCapV;
      end
      StCapV: begin
        cmd_o.cap_v   = 1'b1;
        cmd_o.acc_clr = 1'b1;
        j_d           = '0;
        state_d       = StScan;
      end
      StScan: begin
        cmd_o.acc_en = 1'b1;
        if (j_q == len_i - CW'(1)) begin
          state_d = StDrain;
        end else begin
          j_d = j_q + CW'(1);
        end
      end
      StDrain: state_d = StCmp;
      StCmp: begin
        cmd_o.cmp = 1'b1;
        if (i_q == nd_i - CW'(1)) begin
          state_d = StDone;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = StRdV;
        end
      end
      StDone: begin
        cmd_o.fin = 1'b1;
        state_d   = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

endmodule

[rtl/greedy_sorted_demand_supply_match.sv]
// ----------------------------------------------------------------------------
// greedy_sorted_demand_supply_match
// Counts demands met greedily by distinct supplies of no smaller value.
// ----------------------------------------------------------------------------
// in_i carries load beats (kind demand or supply, with a value) and a finish
// beat. Load beats are taken one per cycle while no count runs and written to
// the demand or supply RAM; a load for a full list is dropped and flagged.
// A finish beat starts the count. The result equals the greedy two-pointer
// match over both sorted lists and is found as the minimum over every demand
// value v of (demands below v) + (supplies at or above v), capped by the
// demand count. For each of nd demands one scan runs over max(nd, ns)
// entries, read through the single read port of each list RAM, and in_i
// is held off until the result is registered for out_o.
// One beat leaves on out_o with matched_count and overflow; after it both
// lists are empty and the flag is clear. A stalled result is held in the
// output register; load beats are still taken, a finish waits for it.
// Reset empties both lists and clears the flag; RAM contents are not reset.
// ----------------------------------------------------------------------------
module greedy_sorted_demand_supply_match #(
  parameter int unsigned ListDepth = gsm_pkg::ListDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gsm_in_if.sink     in_i,
  gsm_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(ListDepth);
  localparam int unsigned CW = $clog2(ListDepth + 1);

  gsm_pkg::cmd_t cmd;
  gsm_pkg::sts_t sts;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] rd_idx, nd, len;

  gsm_ctrl #(.ListDepth(ListDepth)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .kind_i(in_i.kind), .in_ready_o(in_i.ready),
    .sts_i(sts), .nd_i(nd), .len_i(len),
    .cmd_o(cmd), .rd_addr_o(rd_addr), .rd_idx_o(rd_idx)
  );

  gsm_datapath #(.ListDepth(ListDepth)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .rd_addr_i(rd_addr), .rd_idx_i(rd_idx), .value_i(in_i.value),
    .sts_o(sts), .nd_o(nd), .len_o(len),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .matched_o(out_o.matched_count), .overflow_o(out_o.overflow)
  );

endmodule
